// ===== rtl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants of the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    // Depth of the result queue. It must hold at least two items, because one
    // input byte can produce two results.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Decoder modes.
    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ESC      = 3'd1,
        MODE_HEX1     = 3'd2,
        MODE_HEX2     = 3'd3,
        MODE_OCT      = 3'd4,
        MODE_HEX2_BAD = 3'd5
    } t_mode;

    // One decoded result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_hex_digit;
        logic       last_of_run;
    } t_result;

    // Results of one input byte, handed from the decoder to the queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

endpackage

// ===== rtl/esd_decode.sv =====
// ----------------------------------------------------------------------------
// esd_decode
// Escape decode state and the combinational step logic for one input byte.
// ----------------------------------------------------------------------------
module esd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_flush,
    output esd_pkg::t_push o_push
);
    import esd_pkg::*;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_G   = 8'h67;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    localparam logic [7:0] VAL_BS  = 8'h08;
    localparam logic [7:0] VAL_CSI = 8'h9B;
    localparam logic [7:0] VAL_ESC = 8'h1B;
    localparam logic [7:0] VAL_FF  = 8'h0C;
    localparam logic [7:0] VAL_BEL = 8'h07;
    localparam logic [7:0] VAL_LF  = 8'h0A;
    localparam logic [7:0] VAL_CR  = 8'h0D;
    localparam logic [7:0] VAL_TAB = 8'h09;
    localparam logic [7:0] VAL_VT  = 8'h0B;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOWER_A && b <= CH_LOWER_F)
            || (b >= CH_UPPER_A && b <= CH_UPPER_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b - CH_ZERO;
        end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            d = b - CH_LOWER_A + 8'd10;
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            d = b - CH_UPPER_A + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + 8'd32 : b;
    endfunction

    t_mode      r_mode,    n_mode;
    logic [7:0] r_pending, n_pending;
    logic [1:0] r_oct_cnt, n_oct_cnt;

    logic [7:0] c_low;
    logic [1:0] oct_inc;
    logic [7:0] oct_val;
    logic       is_oct;
    t_push      push;

    assign c_low   = to_lower(i_in_byte);
    assign is_oct  = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_SEVEN);
    assign oct_inc = r_oct_cnt + 2'd1;
    assign oct_val = {r_pending[4:0], 3'b000} + (i_in_byte - CH_ZERO);

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_oct_cnt = r_oct_cnt;
        push      = '0;

        if (i_flush) begin
            // The end of the string flushes any open escape or digit run.
            case (r_mode)
                MODE_ESC: begin
                    push.count = 2'd1;
                end
                MODE_HEX1: begin
                    push.count              = 2'd1;
                    push.res0.bad_hex_digit = 1'b1;
                end
                MODE_HEX2, MODE_OCT: begin
                    push.count         = 2'd1;
                    push.res0.out_byte = r_pending;
                end
                MODE_HEX2_BAD: begin
                    push.count              = 2'd1;
                    push.res0.out_byte      = r_pending;
                    push.res0.bad_hex_digit = 1'b1;
                end
                default: begin
                end
            endcase
            n_mode    = MODE_NORMAL;
            n_pending = 8'd0;
            n_oct_cnt = 2'd0;
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    case (c_low)
                        CH_NEWLINE: begin
                        end
                        CH_LOWER_B: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_BS;
                        end
                        CH_LOWER_C: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_CSI;
                        end
                        CH_LOWER_E: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_ESC;
                        end
                        CH_LOWER_F: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_FF;
                        end
                        CH_LOWER_G: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_BEL;
                        end
                        CH_LOWER_N: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_LF;
                        end
                        CH_LOWER_R: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_CR;
                        end
                        CH_LOWER_T: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_TAB;
                        end
                        CH_LOWER_V: begin
                            push.count = 2'd1; push.res0.out_byte = VAL_VT;
                        end
                        CH_LOWER_X: begin
                            n_mode = MODE_HEX1;
                        end
                        CH_RPAREN, CH_BACKSLASH: begin
                            push.count         = 2'd2;
                            push.res0.out_byte = CH_BACKSLASH;
                            push.res1.out_byte = c_low;
                        end
                        default: begin
                            if (is_oct) begin
                                n_pending = i_in_byte - CH_ZERO;
                                n_oct_cnt = 2'd1;
                                n_mode    = MODE_OCT;
                            end else begin
                                push.count         = 2'd1;
                                push.res0.out_byte = c_low;
                            end
                        end
                    endcase
                end
                MODE_HEX1: begin
                    // The first digit is always consumed; a bad one counts as zero.
                    n_pending = {4'd0, hex_val(i_in_byte)};
                    n_mode    = is_hex(i_in_byte) ? MODE_HEX2 : MODE_HEX2_BAD;
                end
                MODE_HEX2, MODE_HEX2_BAD: begin
                    push.count              = 2'd1;
                    push.res0.bad_hex_digit = (r_mode == MODE_HEX2_BAD);
                    n_pending               = 8'd0;
                    if (is_hex(i_in_byte)) begin
                        push.res0.out_byte = {r_pending[3:0], hex_val(i_in_byte)};
                        n_mode             = MODE_NORMAL;
                    end else begin
                        // Value first, then the byte as text; a backslash opens an escape.
                        push.res0.out_byte = r_pending;
                        if (i_in_byte == CH_BACKSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_mode             = MODE_NORMAL;
                            push.count         = 2'd2;
                            push.res1.out_byte = i_in_byte;
                        end
                    end
                end
                MODE_OCT: begin
                    if (is_oct) begin
                        n_pending = oct_val;
                        n_oct_cnt = oct_inc;
                        if (oct_inc == 2'd3 || oct_inc == 2'd0) begin
                            push.count         = 2'd1;
                            push.res0.out_byte = oct_val;
                            n_mode             = MODE_NORMAL;
                            n_pending          = 8'd0;
                            n_oct_cnt          = 2'd0;
                        end
                    end else begin
                        push.count         = 2'd1;
                        push.res0.out_byte = r_pending;
                        n_pending          = 8'd0;
                        n_oct_cnt          = 2'd0;
                        if (i_in_byte == CH_BACKSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_mode             = MODE_NORMAL;
                            push.count         = 2'd2;
                            push.res1.out_byte = i_in_byte;
                        end
                    end
                end
                default: begin
                    if (i_in_byte == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode             = MODE_NORMAL;
                        push.count         = 2'd1;
                        push.res0.out_byte = i_in_byte;
                    end
                end
            endcase
        end

        push.res0.last_of_run = (push.count == 2'd1);
        push.res1.last_of_run = (push.count == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_pending <= 8'd0;
            r_oct_cnt <= 2'd0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_oct_cnt <= n_oct_cnt;
        end
    end

    assign o_push = push;

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_flush) |=> (r_mode == MODE_NORMAL && r_pending == 8'd0
                                   && r_oct_cnt == 2'd0))
        else $error("decoder state not cleared after flush");

    a_oct_cnt_only_in_oct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_OCT) |-> (r_oct_cnt == 2'd0))
        else $error("octal digit count set outside octal mode");

    a_pending_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NORMAL || r_mode == MODE_ESC || r_mode == MODE_HEX1)
            |-> (r_pending == 8'd0))
        else $error("pending value left over outside a digit run");

endmodule

// ===== rtl/esd_outq.sv =====
// ----------------------------------------------------------------------------
// esd_outq
// Small result queue: takes up to two results per cycle, gives one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module esd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_en,
    input  esd_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output esd_pkg::t_result o_result
);
    import esd_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count,  n_count;
    logic [QUEUE_AW-1:0]   wr_ptr_b;
    logic [1:0]            push_n;
    logic                  pop;

    assign push_n   = i_push_en ? i_push.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_b = r_wr_ptr + QUEUE_AW'(1);

    // Room for two more results, whatever this cycle's input byte turns into.
    assign o_room  = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(push_n);
        n_rd_ptr = r_rd_ptr + QUEUE_AW'(pop);
        n_count  = r_count + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && push_n == 2'd0) |=> (r_count == $past(r_count) - QUEUE_CW'(1)))
        else $error("queue count wrong after pop");

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Backslash escape decoder for a byte stream, one text byte per item.
// ----------------------------------------------------------------------------
// The block takes one input item per clock cycle while the queue has room
// and decodes it in that cycle into zero, one or two result items, which
// go into a four-entry result queue. The output side gives one result per
// cycle while the reader is ready, so a stream in which every byte yields
// at most one result runs at one item per cycle; a byte that yields two
// results (an escaped backslash or parenthesis, or a byte other than a
// backslash that cuts a hex or octal digit run short) needs two output
// transfers. Input is taken whenever the queue has room for two results.
module escape_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_flush,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_bad_hex_digit,
    output logic       o_last_of_run
);
    import esd_pkg::*;

    t_push   push;
    t_result result;
    logic    room;
    logic    accept;

    assign o_ready = room;
    assign accept  = i_valid && room;

    esd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_flush   (i_flush),
        .o_push    (push)
    );

    esd_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_out_byte      = result.out_byte;
    assign o_bad_hex_digit = result.bad_hex_digit;
    assign o_last_of_run   = result.last_of_run;

endmodule
